### design/bslh_pkg.sv
`timescale 1ns / 1ps

package bslh_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9e37_79b9;

    // Byte position that completes a 12-byte block
    localparam logic [3:0] BLOCK_LAST = 4'd11;

    // Mix unit: one input stage, one add stage, nine mix rows
    localparam int MIX_ROWS   = 9;
    localparam int PIPE_DEPTH = MIX_ROWS + 2;

    // Lane that a mix row updates
    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;

    localparam logic [1:0] MIX_LANE [MIX_ROWS] = '{
        LANE_A, LANE_B, LANE_C,
        LANE_A, LANE_B, LANE_C,
        LANE_A, LANE_B, LANE_C
    };

    localparam logic [4:0] MIX_SHIFT [MIX_ROWS] = '{
        5'd13, 5'd8, 5'd13,
        5'd12, 5'd16, 5'd5,
        5'd3, 5'd10, 5'd15
    };

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } lanes_t;

    // One launch into the mix unit, carried alongside the lanes
    typedef struct packed {
        logic        fin;      // key ends with this item
        logic        blk;      // item completes a full block
        logic        has_blk;  // key had a full block before this item
        logic [31:0] seed_c;   // lane c start value of the key
        logic [31:0] wa;       // lane a bytes of the open block
        logic [31:0] wb;       // lane b bytes of the open block
        logic [23:0] pend;     // lane c bytes 8..10 of the open block
        logic [7:0]  kbyte;    // byte of this item
        logic [31:0] count;    // key length before this item
        logic        inc;      // this item carries a byte
    } entry_t;

    typedef struct packed {
        logic   launch;     // accepted item needs the mix unit
        logic   near_full;  // next byte completes a block
        entry_t entry;
    } gather_out_t;

    function automatic lanes_t mix_step(input lanes_t l, input logic [3:0] row);
        lanes_t     r;
        logic [4:0] d;
        r = l;
        d = MIX_SHIFT[row];
        case (MIX_LANE[row])
            LANE_A:  r.a = (l.a - l.b - l.c) ^ (l.c >> d);
            LANE_B:  r.b = (l.b - l.c - l.a) ^ (l.a << d);
            LANE_C:  r.c = (l.c - l.a - l.b) ^ (l.b >> d);
            default: r = l;
        endcase
        return r;
    endfunction

endpackage

### design/bslh_mix_pipe.sv
`timescale 1ns / 1ps

module bslh_mix_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bslh_pkg::lanes_t  in_lanes,
    input  bslh_pkg::lanes_t  in_add,
    input  logic [31:0]       in_add_c2,
    input  bslh_pkg::entry_t  in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output bslh_pkg::lanes_t  out_lanes,
    output bslh_pkg::entry_t  out_side
);

    logic              vld_reg   [bslh_pkg::PIPE_DEPTH];
    bslh_pkg::lanes_t  lanes_reg [bslh_pkg::PIPE_DEPTH];
    bslh_pkg::entry_t  side_reg  [bslh_pkg::PIPE_DEPTH];
    bslh_pkg::lanes_t  add_reg;
    logic [31:0]       add_c2_reg;
    logic [bslh_pkg::PIPE_DEPTH:0] rdy;
    bslh_pkg::lanes_t  sum;

    // A stage takes new data when it is empty or its successor moves
    always_comb
    begin
        rdy[bslh_pkg::PIPE_DEPTH] = out_ready;
        for (int i = bslh_pkg::PIPE_DEPTH - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i + 1];
        end
    end

    always_comb
    begin
        sum.a = lanes_reg[0].a + add_reg.a;
        sum.b = lanes_reg[0].b + add_reg.b;
        sum.c = lanes_reg[0].c + add_reg.c + add_c2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bslh_pkg::PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rdy[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < bslh_pkg::PIPE_DEPTH; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            lanes_reg[0] <= in_lanes;
            add_reg      <= in_add;
            add_c2_reg   <= in_add_c2;
            side_reg[0]  <= in_side;
        end
    end

    for (genvar i = 1; i < bslh_pkg::PIPE_DEPTH; i++)
    begin : g_stage
        bslh_pkg::lanes_t nxt;

        if (i == 1)
        begin : g_add
            assign nxt = sum;
        end
        else
        begin : g_mix
            assign nxt = bslh_pkg::mix_step(lanes_reg[i - 1], 4'(i - 2));
        end

        always_ff @(posedge clk)
        begin
            if (rdy[i])
            begin
                lanes_reg[i] <= nxt;
                side_reg[i]  <= side_reg[i - 1];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[bslh_pkg::PIPE_DEPTH - 1];
    assign out_lanes = lanes_reg[bslh_pkg::PIPE_DEPTH - 1];
    assign out_side  = side_reg[bslh_pkg::PIPE_DEPTH - 1];

endmodule

### design/bslh_gather.sv
`timescale 1ns / 1ps

module bslh_gather (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             key_byte,
    input  logic                   has_byte,
    input  logic                   last,
    input  logic [31:0]            seed,
    output bslh_pkg::gather_out_t  status
);

    logic        active_reg,  active_next;
    logic [3:0]  pos_reg,     pos_next;
    logic [31:0] total_reg,   total_next;
    logic [31:0] wa_reg,      wa_next;
    logic [31:0] wb_reg,      wb_next;
    logic [23:0] pend_reg,    pend_next;
    logic        has_blk_reg, has_blk_next;
    logic [31:0] seed_c_reg,  seed_c_next;

    logic [3:0]  eff_pos;
    logic [31:0] eff_total;
    logic [31:0] eff_wa;
    logic [31:0] eff_wb;
    logic [23:0] eff_pend;
    logic        eff_has_blk;
    logic [31:0] eff_seed;
    logic [31:0] put_wa;
    logic [31:0] put_wb;
    logic [23:0] put_pend;
    logic        act;
    logic        blk;

    always_comb
    begin
        // A new key starts from a clean block state
        if (active_reg)
        begin
            eff_pos     = pos_reg;
            eff_total   = total_reg;
            eff_wa      = wa_reg;
            eff_wb      = wb_reg;
            eff_pend    = pend_reg;
            eff_has_blk = has_blk_reg;
            eff_seed    = seed_c_reg;
        end
        else
        begin
            eff_pos     = '0;
            eff_total   = '0;
            eff_wa      = '0;
            eff_wb      = '0;
            eff_pend    = '0;
            eff_has_blk = 1'b0;
            eff_seed    = seed;
        end

        act = has_byte || last;
        blk = has_byte && (eff_pos == bslh_pkg::BLOCK_LAST);

        put_wa   = eff_wa;
        put_wb   = eff_wb;
        put_pend = eff_pend;
        if (has_byte)
        begin
            case (eff_pos[3:2])
                2'd0:    put_wa[{eff_pos[1:0], 3'b000} +: 8] = key_byte;
                2'd1:    put_wb[{eff_pos[1:0], 3'b000} +: 8] = key_byte;
                default:
                begin
                    if (!blk)
                    begin
                        put_pend[{eff_pos[1:0], 3'b000} +: 8] = key_byte;
                    end
                end
            endcase
        end

        status.launch          = act && (blk || last);
        status.near_full       = eff_pos == bslh_pkg::BLOCK_LAST;
        status.entry.fin       = last;
        status.entry.blk       = blk;
        status.entry.has_blk   = eff_has_blk;
        status.entry.seed_c    = eff_seed;
        status.entry.wa        = put_wa;
        status.entry.wb        = put_wb;
        status.entry.pend      = put_pend;
        status.entry.kbyte     = key_byte;
        status.entry.count     = eff_total;
        status.entry.inc       = has_byte;

        active_next  = active_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        wa_next      = wa_reg;
        wb_next      = wb_reg;
        pend_next    = pend_reg;
        has_blk_next = has_blk_reg;
        seed_c_next  = seed_c_reg;
        if (accept && act)
        begin
            active_next = !last;
            total_next  = eff_total + 32'(has_byte);
            seed_c_next = eff_seed;
            if (blk)
            begin
                pos_next     = '0;
                wa_next      = '0;
                wb_next      = '0;
                pend_next    = '0;
                has_blk_next = 1'b1;
            end
            else
            begin
                pos_next     = eff_pos + 4'(has_byte);
                wa_next      = put_wa;
                wb_next      = put_wb;
                pend_next    = put_pend;
                has_blk_next = eff_has_blk;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg   <= total_next;
        wa_reg      <= wa_next;
        wb_reg      <= wb_next;
        pend_reg    <= pend_next;
        has_blk_reg <= has_blk_next;
        seed_c_reg  <= seed_c_next;
    end

endmodule

### design/byte_stream_lookup2_hash.sv
`timescale 1ns / 1ps

// Streaming 32-bit lookup2 hash. Key bytes enter one per cycle on the input
// channel while in_ready is high; the item marked last ends the key, and its
// hash leaves the output channel once it has passed both mix pipelines. The
// sustained rate is one item per cycle when the output is not held back, keys
// may follow each other without a gap, and several keys can be in flight at
// once. Two eleven-stage mix pipelines set the latency: the first mixes each
// full 12-byte block, the second adds the tail and length and runs the final
// mix. An item at the twelfth byte of a block is held off while the previous
// block, of this key or an earlier one, is still inside the first pipeline,
// which can only occur while the output is stalled. The seed is sampled when
// a key starts; write it between keys.

module byte_stream_lookup2_hash (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  key_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic [31:0]            seed_reg;
    logic                   inflight_reg, inflight_next;
    bslh_pkg::lanes_t       chain_reg;
    bslh_pkg::gather_out_t  g;
    logic                   accept;
    logic                   blk_accept;

    logic                   p1_in_valid, p1_in_ready;
    bslh_pkg::lanes_t       p1_in_lanes, p1_in_add;
    logic                   p1_out_valid, p1_out_ready;
    bslh_pkg::lanes_t       p1_out_lanes;
    bslh_pkg::entry_t       p1_out_side;
    logic                   p1_blk_exit;

    logic                   p2_in_valid, p2_in_ready;
    bslh_pkg::lanes_t       p2_in_lanes, p2_in_add;
    logic [31:0]            p2_in_add_c2;
    bslh_pkg::lanes_t       p2_out_lanes;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            seed_reg <= cfg_data;
        end
    end

    bslh_gather u_gather (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .key_byte (key_byte),
        .has_byte (has_byte),
        .last     (last),
        .seed     (seed_reg),
        .status   (g)
    );

    // Hold off any item at the twelfth byte position until the prior block has left pipe 1
    assign in_ready   = p1_in_ready && !(inflight_reg && g.near_full);
    assign accept     = in_valid && in_ready;
    assign blk_accept = accept && g.entry.blk;

    always_comb
    begin
        if (g.entry.has_blk)
        begin
            p1_in_lanes = chain_reg;
        end
        else
        begin
            p1_in_lanes.a = bslh_pkg::GOLDEN_RATIO;
            p1_in_lanes.b = bslh_pkg::GOLDEN_RATIO;
            p1_in_lanes.c = g.entry.seed_c;
        end
        p1_in_add.a = g.entry.wa;
        p1_in_add.b = g.entry.wb;
        p1_in_add.c = {g.entry.kbyte, g.entry.pend};
    end

    assign p1_in_valid = accept && g.launch;

    bslh_mix_pipe u_block_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_in_valid),
        .in_ready  (p1_in_ready),
        .in_lanes  (p1_in_lanes),
        .in_add    (p1_in_add),
        .in_add_c2 (32'd0),
        .in_side   (g.entry),
        .out_valid (p1_out_valid),
        .out_ready (p1_out_ready),
        .out_lanes (p1_out_lanes),
        .out_side  (p1_out_side)
    );

    // Block-only entries retire here; finals move on to pipe 2
    assign p1_out_ready = !p1_out_side.fin || p2_in_ready;
    assign p2_in_valid  = p1_out_valid && p1_out_side.fin;
    assign p1_blk_exit  = p1_out_valid && p1_out_ready && p1_out_side.blk;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (blk_accept)
        begin
            inflight_next = 1'b1;
        end
        else if (p1_blk_exit)
        begin
            inflight_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 1'b0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_blk_exit)
        begin
            chain_reg <= p1_out_lanes;
        end
    end

    always_comb
    begin
        if (p1_out_side.blk)
        begin
            p2_in_lanes  = p1_out_lanes;
            p2_in_add.a  = '0;
            p2_in_add.b  = '0;
            p2_in_add_c2 = {24'd0, 7'd0, p1_out_side.inc};
        end
        else
        begin
            if (p1_out_side.has_blk)
            begin
                p2_in_lanes = chain_reg;
            end
            else
            begin
                p2_in_lanes.a = bslh_pkg::GOLDEN_RATIO;
                p2_in_lanes.b = bslh_pkg::GOLDEN_RATIO;
                p2_in_lanes.c = p1_out_side.seed_c;
            end
            p2_in_add.a  = p1_out_side.wa;
            p2_in_add.b  = p1_out_side.wb;
            // Tail c bytes sit one byte up; the low byte is free for the increment
            p2_in_add_c2 = {p1_out_side.pend, 7'd0, p1_out_side.inc};
        end
        p2_in_add.c = p1_out_side.count;
    end

    bslh_mix_pipe u_final_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_in_valid),
        .in_ready  (p2_in_ready),
        .in_lanes  (p2_in_lanes),
        .in_add    (p2_in_add),
        .in_add_c2 (p2_in_add_c2),
        .in_side   (p1_out_side),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_lanes (p2_out_lanes),
        .out_side  ()
    );

    assign hash_value = p2_out_lanes.c;

    a_blk_sets_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        blk_accept |=> inflight_reg)
        else $error("block transfer did not mark a block in flight");

    a_blk_exit_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        p1_blk_exit |-> inflight_reg)
        else $error("block left the mix pipeline with no block in flight");

    a_one_block: assert property (@(posedge clk) disable iff (!rst_n)
        blk_accept |-> !inflight_reg)
        else $error("second block entered while the previous one is mixing");

    a_final_path: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_out_valid && !p1_out_side.fin) |-> p1_out_side.blk)
        else $error("non-final entry without a block reached pipe 1 output");

endmodule
